>>> rtl/ehp_pkg.sv
package ehp_pkg;

  // Byte counter width; it covers the longest header of eighteen bytes.
  localparam int CNT_W = 5;

  // Byte positions in the frame header, as the count of bytes taken so far.
  localparam logic [CNT_W-1:0] DST_END   = CNT_W'(6);
  localparam logic [CNT_W-1:0] SRC_END   = CNT_W'(12);
  localparam logic [CNT_W-1:0] HDR_END   = CNT_W'(14);
  localparam logic [CNT_W-1:0] TAG_END   = CNT_W'(16);
  localparam logic [CNT_W-1:0] VLAN_END  = CNT_W'(18);
  localparam logic [CNT_W-1:0] HDR_LAST  = HDR_END - CNT_W'(1);
  localparam logic [CNT_W-1:0] VLAN_LAST = VLAN_END - CNT_W'(1);

  localparam logic [15:0] TPID_8021Q = 16'h8100;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_HDR  = 2'd1;
  localparam logic [1:0] STATUS_NO_TAG  = 2'd2;

  // Destination address classes.
  localparam logic [2:0] CLASS_ZERO       = 3'd0;
  localparam logic [2:0] CLASS_UNICAST    = 3'd1;
  localparam logic [2:0] CLASS_BROADCAST  = 3'd2;
  localparam logic [2:0] CLASS_L2_MCAST   = 3'd3;
  localparam logic [2:0] CLASS_L3_MCAST   = 3'd4;
  localparam logic [2:0] CLASS_LINK_LOCAL = 3'd5;

  // One input word as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [11:0] vlan_id;
    logic        drop_eligible;
    logic [2:0]  priority_res;
    logic        tagged_res;
    logic [1:0]  status;
    logic [2:0]  dst_class;
  } res_t;

endpackage

>>> rtl/ehp_if.sv
// Byte stream channel into the parser.
interface ehp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source (output valid, data_byte, frame_end, input ready);
  modport sink (input valid, data_byte, frame_end, output ready);
endinterface

// Parsed header channel out of the parser.
interface ehp_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic [15:0] ether_type;
  logic [11:0] vlan_id;
  logic        drop_eligible;
  logic [2:0]  priority_res;
  logic        tagged_res;
  logic [1:0]  status;
  logic [2:0]  dst_class;

  modport source (output valid, dst_mac, src_mac, ether_type, vlan_id, drop_eligible,
                  priority_res, tagged_res, status, dst_class, input ready);
  modport sink (input valid, dst_mac, src_mac, ether_type, vlan_id, drop_eligible,
                priority_res, tagged_res, status, dst_class, output ready);
endinterface

>>> rtl/ethernet_header_parser_unit.sv
// Ethernet header parser with optional 802.1Q tag. Frame bytes arrive one word
// per cycle in wire order, with frame_end on the last byte; the block gathers
// the destination and source MAC and the EtherType, and when vlan_enable is set
// and the type is 0x8100 it also reads the tag and the inner type. One result
// word leaves per frame: the header fields with status ok once the header is
// complete, or an error status with all other fields zero if the frame ends
// inside the header. The block takes one byte every cycle; a byte passes the
// input register, the parser state update and the result register, in that
// order. Only a stalled result word holds back the input. vlan_enable is
// sampled when the fourteenth byte is parsed and may be written only while
// the block is idle.
module ethernet_header_parser_unit
  import ehp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  ehp_in_if.sink    in_i,
  ehp_out_if.source out_o
);

  in_word_t in_word;
  in_word_t stage_word;
  logic     stage_valid;
  logic     adv;
  logic     fire;
  logic     res_valid;
  res_t     res;
  res_t     out_res;

  assign in_word.data_byte = in_i.data_byte;
  assign in_word.frame_end = in_i.frame_end;

  // A byte in the input register is parsed whenever the result side can move.
  assign fire = stage_valid && adv;

  ehp_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .word_i  (in_word),
    .adv_i   (adv),
    .valid_o (stage_valid),
    .word_o  (stage_word)
  );

  ehp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .word_i      (stage_word),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ehp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_i     (out_o.ready),
    .adv_o       (adv),
    .valid_o     (out_o.valid),
    .res_o       (out_res)
  );

  // Result word onto the output channel.
  assign out_o.dst_mac       = out_res.dst_mac;
  assign out_o.src_mac       = out_res.src_mac;
  assign out_o.ether_type    = out_res.ether_type;
  assign out_o.vlan_id       = out_res.vlan_id;
  assign out_o.drop_eligible = out_res.drop_eligible;
  assign out_o.priority_res  = out_res.priority_res;
  assign out_o.tagged_res    = out_res.tagged_res;
  assign out_o.status        = out_res.status;
  assign out_o.dst_class     = out_res.dst_class;

endmodule

>>> rtl/ehp_in_reg.sv
module ehp_in_reg
  import ehp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  in_word_t word_i,
  input  logic     adv_i,
  output logic     valid_o,
  output in_word_t word_o
);

  logic     valid_q;
  in_word_t word_q;

  // The register takes a new word when empty or when its word moves on.
  assign ready_o = !valid_q || adv_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

>>> rtl/ehp_parser.sv
module ehp_parser
  import ehp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     fire_i,
  input  in_word_t word_i,
  output logic     res_valid_o,
  output res_t     res_o
);

  logic             vlan_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic             tagged_q, tagged_d;
  logic [47:0]      dst_q, dst_d;
  logic [47:0]      src_q, src_d;
  logic [15:0]      type_q, type_d;
  logic [15:0]      tag_q, tag_d;
  logic             hdr_done;

  // Sort a destination address into its class.
  function automatic logic [2:0] classify(input logic [47:0] a);
    logic [2:0] c;
    if (a == 48'h0) begin
      c = CLASS_ZERO;
    end else if (a == 48'hFFFF_FFFF_FFFF) begin
      c = CLASS_BROADCAST;
    end else if (a[47:8] == 40'h01_80C2_0000) begin
      c = CLASS_LINK_LOCAL;
    end else if (a[47:24] == 24'h0180C2) begin
      c = CLASS_L2_MCAST;
    end else if (a[47:24] == 24'h01005E) begin
      c = CLASS_L3_MCAST;
    end else begin
      c = CLASS_UNICAST;
    end
    return c;
  endfunction

  // Header field gathering and result forming for one byte.
  always_comb begin
    cnt_d       = cnt_q;
    done_d      = done_q;
    tagged_d    = tagged_q;
    dst_d       = dst_q;
    src_d       = src_q;
    type_d      = type_q;
    tag_d       = tag_q;
    hdr_done    = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire_i) begin
      if (done_q) begin
        // Trailing bytes are skipped until the frame ends.
        if (word_i.frame_end) begin
          cnt_d    = '0;
          done_d   = 1'b0;
          tagged_d = 1'b0;
        end
      end else begin
        priority if (cnt_q < DST_END) begin
          dst_d = {dst_q[39:0], word_i.data_byte};
        end else if (cnt_q < SRC_END) begin
          src_d = {src_q[39:0], word_i.data_byte};
        end else if (cnt_q < HDR_END) begin
          type_d = {type_q[7:0], word_i.data_byte};
          if (cnt_q == HDR_LAST) begin
            if (vlan_q && (type_d == TPID_8021Q)) begin
              tagged_d = 1'b1;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end else if (cnt_q < TAG_END) begin
          tag_d = {tag_q[7:0], word_i.data_byte};
        end else begin
          type_d = {type_q[7:0], word_i.data_byte};
          if (cnt_q == VLAN_LAST) begin
            hdr_done = 1'b1;
          end
        end
        cnt_d = cnt_q + CNT_W'(1);

        if (hdr_done) begin
          res_valid_o      = 1'b1;
          res_o.dst_mac    = dst_d;
          res_o.src_mac    = src_d;
          res_o.ether_type = type_d;
          res_o.status     = STATUS_OK;
          res_o.dst_class  = classify(dst_d);
          if (tagged_d) begin
            res_o.vlan_id       = tag_d[11:0];
            res_o.drop_eligible = tag_d[12];
            res_o.priority_res  = tag_d[15:13];
            res_o.tagged_res    = 1'b1;
          end
          done_d = 1'b1;
          if (word_i.frame_end) begin
            cnt_d    = '0;
            done_d   = 1'b0;
            tagged_d = 1'b0;
          end
        end else if (word_i.frame_end) begin
          // Frame ended before the header was complete.
          res_valid_o  = 1'b1;
          res_o.status = tagged_d ? STATUS_NO_TAG : STATUS_NO_HDR;
          cnt_d        = '0;
          done_d       = 1'b0;
          tagged_d     = 1'b0;
        end
      end
    end
  end

  // Control state and the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlan_q   <= 1'b1;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      tagged_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        vlan_q <= cfg_wdata_i;
      end
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      tagged_q <= tagged_d;
    end
  end

  // Header field shift registers.
  always_ff @(posedge clk_i) begin
    dst_q  <= dst_d;
    src_q  <= src_d;
    type_q <= type_d;
    tag_q  <= tag_d;
  end

`ifndef SYNTH
  // Skipping trailing bytes happens only right after a complete header.
  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (cnt_q == HDR_END || cnt_q == VLAN_END))
    else $error("header done flag set at an unexpected byte count");

  // A tag is only known once the outer type has been read.
  a_tag_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tagged_q |-> (cnt_q >= HDR_END && cnt_q <= VLAN_END))
    else $error("tagged flag set before the outer type was read");

  // The last byte of a frame still in its header always yields a result.
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !done_q && word_i.frame_end) |-> res_valid_o)
    else $error("frame ended inside the header without a result");

  // Parsing never runs past the tagged header length.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= VLAN_END)
    else $error("byte count ran past the header");
`endif

endmodule

>>> rtl/ehp_out_reg.sv
module ehp_out_reg
  import ehp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  logic res_valid_i,
  input  res_t res_i,
  input  logic ready_i,
  output logic adv_o,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  // The result register can take a new word when empty or being emptied.
  assign adv_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_o) begin
      valid_q <= fire_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && fire_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> bench/ehp_header_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the header parser, predicts one header word per
// frame from the accepted bytes and compares every accepted header word with
// the oldest prediction.
module ehp_header_checker
  import ehp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  ehp_in_if    byte_ch_i,
  ehp_out_if   hdr_ch_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   ok_count_o,
  output int   tagged_count_o,
  output int   short_count_o
);

  // Predicted parser state.
  logic             vlan_en;
  logic [CNT_W-1:0] hdr_cnt;
  logic             skip_rest;
  logic             tag_seen;
  logic [47:0]      dst_q;
  logic [47:0]      src_q;
  logic [15:0]      type_q;
  logic [15:0]      tci_q;

  // Header words predicted but not yet seen on the output.
  res_t headers_due[$];

  int errs;
  int n_ok;
  int n_tagged;
  int n_short;

  // Start of a new frame: all gathered fields go back to zero.
  task automatic clear_frame();
    hdr_cnt   = '0;
    skip_rest = 1'b0;
    tag_seen  = 1'b0;
    dst_q     = '0;
    src_q     = '0;
    type_q    = '0;
    tci_q     = '0;
  endtask

  // Class of a destination address; link-local control wins over L2 multicast.
  function automatic logic [2:0] addr_class(input logic [47:0] addr);
    if (addr == 48'h0) return CLASS_ZERO;
    if (addr == 48'hFFFF_FFFF_FFFF) return CLASS_BROADCAST;
    if (addr[47:8] == 40'h01_80_C2_00_00) return CLASS_LINK_LOCAL;
    if (addr[47:24] == 24'h01_80_C2) return CLASS_L2_MCAST;
    if (addr[47:24] == 24'h01_00_5E) return CLASS_L3_MCAST;
    return CLASS_UNICAST;
  endfunction

  // Advances the predicted state by one frame byte and queues any header word.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    res_t hdr;
    logic done;
    hdr  = '0;
    done = 1'b0;
    if (skip_rest) begin
      if (last) clear_frame();
      return;
    end
    if (hdr_cnt < DST_END) begin
      dst_q = {dst_q[39:0], b};
    end else if (hdr_cnt < SRC_END) begin
      src_q = {src_q[39:0], b};
    end else if (hdr_cnt < HDR_END) begin
      type_q = {type_q[7:0], b};
      if (hdr_cnt == HDR_LAST) begin
        if (vlan_en && type_q == TPID_8021Q) begin
          tag_seen = 1'b1;
        end else begin
          done = 1'b1;
        end
      end
    end else if (hdr_cnt < TAG_END) begin
      tci_q = {tci_q[7:0], b};
    end else begin
      type_q = {type_q[7:0], b};
      if (hdr_cnt == VLAN_LAST) done = 1'b1;
    end
    hdr_cnt = hdr_cnt + CNT_W'(1);

    if (done) begin
      hdr.dst_mac    = dst_q;
      hdr.src_mac    = src_q;
      hdr.ether_type = type_q;
      if (tag_seen) begin
        hdr.vlan_id       = tci_q[11:0];
        hdr.drop_eligible = tci_q[12];
        hdr.priority_res  = tci_q[15:13];
        hdr.tagged_res    = 1'b1;
      end
      hdr.status    = STATUS_OK;
      hdr.dst_class = addr_class(dst_q);
      headers_due.push_back(hdr);
      skip_rest = 1'b1;
      if (last) clear_frame();
    end else if (last) begin
      // A frame cut short reports only its status.
      hdr.status = tag_seen ? STATUS_NO_TAG : STATUS_NO_HDR;
      headers_due.push_back(hdr);
      clear_frame();
    end
  endtask

  function automatic int field_diff(input string name, input logic [47:0] want,
                                    input logic [47:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compares one accepted header word with the oldest prediction.
  task automatic check_header();
    res_t want;
    if (headers_due.size() == 0) begin
      $error("header word with no frame pending: dst 0x%0h status %0d",
             hdr_ch_i.dst_mac, hdr_ch_i.status);
      errs++;
      return;
    end
    want = headers_due.pop_front();
    errs += field_diff("dst_mac", want.dst_mac, hdr_ch_i.dst_mac);
    errs += field_diff("src_mac", want.src_mac, hdr_ch_i.src_mac);
    errs += field_diff("ether_type", 48'(want.ether_type), 48'(hdr_ch_i.ether_type));
    errs += field_diff("vlan_id", 48'(want.vlan_id), 48'(hdr_ch_i.vlan_id));
    errs += field_diff("drop_eligible", 48'(want.drop_eligible),
                       48'(hdr_ch_i.drop_eligible));
    errs += field_diff("priority_res", 48'(want.priority_res),
                       48'(hdr_ch_i.priority_res));
    errs += field_diff("tagged_res", 48'(want.tagged_res), 48'(hdr_ch_i.tagged_res));
    errs += field_diff("status", 48'(want.status), 48'(hdr_ch_i.status));
    errs += field_diff("dst_class", 48'(want.dst_class), 48'(hdr_ch_i.dst_class));
    if (want.status == STATUS_OK) begin
      n_ok++;
      if (want.tagged_res) n_tagged++;
    end else begin
      n_short++;
    end
  endtask

  // Everything is sampled at the rising edge, before the edge's updates land.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlan_en = 1'b1;
      clear_frame();
      headers_due.delete();
      errs     = 0;
      n_ok     = 0;
      n_tagged = 0;
      n_short  = 0;
      fail_count_o   <= 0;
      pending_o      <= 0;
      ok_count_o     <= 0;
      tagged_count_o <= 0;
      short_count_o  <= 0;
    end else begin
      if (cfg_we_i) vlan_en = cfg_wdata_i;
      if (hdr_ch_i.valid && hdr_ch_i.ready) check_header();
      if (byte_ch_i.valid && byte_ch_i.ready) begin
        parse_byte(byte_ch_i.data_byte, byte_ch_i.frame_end);
      end
      fail_count_o   <= errs;
      pending_o      <= headers_due.size();
      ok_count_o     <= n_ok;
      tagged_count_o <= n_tagged;
      short_count_o  <= n_short;
    end
  end

endmodule

>>> bench/ethernet_header_parser_unit_tb.sv
`timescale 1ns / 100ps

// Drives frames into the header parser and takes header words out, both with
// random idling; the checker beside the block does the prediction.
module ethernet_header_parser_unit_tb;
  import ehp_pkg::*;

  localparam int RANDOM_BYTES = 1760;
  localparam int PHASES       = 8;
  localparam int HOLD_PHASE   = 2;
  localparam int LONG_HOLD    = 240;
  localparam int STALL_LIMIT  = 3000;
  localparam int SETTLE       = 4;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic cfg_we_i    = 1'b0;
  logic cfg_wdata_i = 1'b0;

  ehp_in_if  in_ch ();
  ehp_out_if out_ch ();

  int fail_count;
  int pending;
  int ok_count;
  int tagged_count;
  int short_count;

  logic vlan_on     = 1'b1;
  logic send_gaps   = 1'b1;
  logic take_gaps   = 1'b1;
  logic hold_req    = 1'b0;
  logic hold_done   = 1'b0;
  int   rush_frames = 0;
  int   sent_bytes  = 0;
  int   n_frames    = 0;
  int   stall_cycles = 0;

  ethernet_header_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  ehp_header_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .byte_ch_i      (in_ch),
    .hdr_ch_i       (out_ch),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .ok_count_o     (ok_count),
    .tagged_count_o (tagged_count),
    .short_count_o  (short_count)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Timed out: no word moved for %0d cycles.", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offers one byte after a random gap and waits until it is taken.
  task automatic put_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = send_gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.frame_end <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // Sends a frame of len bytes; bytes past the tagged header are random payload.
  task automatic send_frame(input logic [47:0] dst, input logic [47:0] src,
                            input logic [15:0] etype, input logic [15:0] tci,
                            input logic [15:0] inner, input int len);
    logic [143:0] hdr;
    logic [7:0]   b;
    hdr = {dst, src, etype, tci, inner};
    if (rush_frames > 0) begin
      rush_frames--;
      send_gaps = 1'b0;
    end else begin
      send_gaps = ($urandom_range(0, 2) != 0);
    end
    for (int i = 0; i < len; i++) begin
      b = (i < 18) ? hdr[143 - 8 * i -: 8] : 8'($urandom);
      put_byte(b, i == len - 1);
    end
    sent_bytes += len;
    n_frames++;
  endtask

  // Destination addresses spread over every class and the edges between them.
  function automatic logic [47:0] pick_dst();
    case ($urandom_range(0, 8))
      0: return 48'h0;
      1: return 48'hFFFF_FFFF_FFFF;
      2: return {40'h01_80_C2_00_00, 8'($urandom)};
      3: return {24'h01_80_C2, 24'($urandom)};
      4: return {24'h01_00_5E, 24'($urandom)};
      5: return 48'hFFFF_FFFF_FFFF ^ (48'h1 << $urandom_range(0, 47));
      6: return {8'h01, 40'({$urandom, $urandom})};
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  // Mostly complete headers with a little payload, some cut short, some long.
  task automatic random_frame();
    logic [15:0] etype;
    int hlen;
    int len;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: etype = TPID_8021Q;
      5:             etype = 16'h0800;
      6:             etype = {8'h81, 8'($urandom)};
      default:       etype = 16'($urandom);
    endcase
    hlen = (vlan_on && etype == TPID_8021Q) ? 18 : 14;
    case ($urandom_range(0, 9))
      0:       len = $urandom_range(1, hlen - 1);
      1:       len = hlen + $urandom_range(4, 30);
      default: len = hlen + $urandom_range(0, 3);
    endcase
    send_frame(pick_dst(), 48'({$urandom, $urandom}), etype, 16'($urandom),
               16'($urandom), len);
  endtask

  // Stops offering and waits until every header word is out and the block is quiet.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_vlan_enable(input logic en);
    cfg_wdata_i <= en;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    vlan_on = en;
  endtask

  // Header word receiver: random stalls, one long hold-off on request.
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) take_gaps = !take_gaps;
      gap = take_gaps ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // Frame stimulus and the verdict.
  initial begin
    int goal;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.frame_end <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames with the tag enabled out of reset.
    send_frame(48'hFFFF_FFFF_FFFF, 48'h00_11_22_33_44_55, 16'h0800, 16'h0, 16'h0, 14);
    send_frame(48'h0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16);
    send_frame(48'h01_80_C2_00_00_0E, 48'h02_00_00_00_00_01, TPID_8021Q, 16'hFFFF,
               16'h86DD, 18);
    send_frame(48'h01_80_C2_00_01_00, 48'h0, TPID_8021Q, 16'h0000, 16'h0000, 20);
    send_frame(48'h01_00_5E_7F_FF_FA, 48'hAA_BB_CC_DD_EE_FF, TPID_8021Q, 16'hE00A,
               16'h0800, 15);
    send_frame(48'h12_34_56_78_9A_BC, 48'h0, 16'h0, 16'h0, 16'h0, 1);
    send_frame(48'h12_34_56_78_9A_BC, 48'h5A_5A_5A_5A_5A_5A, TPID_8021Q, 16'h0,
               16'h0, 13);
    send_frame(48'h02_AB_CD_EF_01_23, 48'h0, TPID_8021Q, 16'h1FFF, 16'h88F7, 17);
    drain_block();

    // With the tag disabled, 0x8100 ends the header at the type.
    write_vlan_enable(1'b0);
    send_frame(48'h01_80_C2_00_00_00, 48'h1, TPID_8021Q, 16'hFFFF, 16'hFFFF, 18);
    send_frame(48'h01_00_5E_00_00_01, 48'h1, TPID_8021Q, 16'h0, 16'h0, 14);
    drain_block();

    // Random phases, alternating the tag setting; one phase holds off results.
    for (int phase = 0; phase < PHASES; phase++) begin
      write_vlan_enable(phase[0]);
      if (phase == HOLD_PHASE) begin
        hold_req    = 1'b1;
        rush_frames = 12;
      end
      goal = sent_bytes + RANDOM_BYTES / PHASES;
      while (sent_bytes < goal) random_frame();
      drain_block();
    end

    $display("Checked %0d header words: %0d complete (%0d with an 802.1Q tag), %0d short.",
             ok_count + short_count, ok_count, tagged_count, short_count);
    $display("Sent %0d frames (%0d bytes) under both tag settings, %0s.",
             n_frames, sent_bytes,
             hold_done ? "including a long result stall" : "without the long result stall");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ehp_pkg.sv
rtl/ehp_if.sv
rtl/ehp_in_reg.sv
rtl/ehp_parser.sv
rtl/ehp_out_reg.sv
rtl/ethernet_header_parser_unit.sv
bench/ehp_header_checker.sv
bench/ethernet_header_parser_unit_tb.sv
